// ===== hdl/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and constants of the round-robin task scheduler
// Slot count, field types, codes and small helpers used by the queue and top.
// ----------------------------------------------------------------------------
package rrts_pkg;

    // Number of task slots and the widths that follow from it
    localparam int TASK_SLOTS = 16;
    localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int FILL_W     = $clog2(TASK_SLOTS + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_SLOT      = 2'd1;

    // Reset values
    localparam logic [15:0] QUANTUM_RESET = 16'd10;

    // Action codes
    localparam logic [1:0] ACT_TICK     = 2'd0;
    localparam logic [1:0] ACT_ENQUEUE  = 2'd1;
    localparam logic [1:0] ACT_SCHEDULE = 2'd2;
    localparam logic [1:0] ACT_NOP      = 2'd3;

    // Target list codes
    localparam logic [1:0] TGT_FREE     = 2'd0;
    localparam logic [1:0] TGT_READY    = 2'd1;
    localparam logic [1:0] TGT_KEYBOARD = 2'd2;
    localparam logic [1:0] TGT_OTHER    = 2'd3;

    // Slot state codes
    localparam logic [1:0] TS_READY   = 2'd0;
    localparam logic [1:0] TS_RUN     = 2'd1;
    localparam logic [1:0] TS_BLOCKED = 2'd2;
    localparam logic [1:0] TS_ZOMBIE  = 2'd3;

    // One input item
    typedef struct packed {
        logic [1:0] action;
        logic [3:0] task_slot;
        logic [1:0] target_list;
        logic       keys_pending;
        logic       uart_has_data;
    } t_item;

    // One result item
    typedef struct packed {
        logic [3:0]  running_slot;
        logic        switched;
        logic        quantum_expired;
        logic [1:0]  slot_state;
        logic [31:0] switch_total;
        logic [31:0] tick_total;
        logic        queue_full;
        logic [4:0]  ready_count;
        logic [4:0]  waiting_count;
    } t_result;

    // Queue operation request for one step
    typedef struct packed {
        logic push;   // push an entry
        logic front;  // push at the head instead of the tail
        logic pop;    // remove the head entry
    } t_q_ctrl;

    // Reduce a 4-bit slot number modulo the slot count
    function automatic logic [SLOT_W-1:0] slot_mod(input logic [3:0] x);
        logic [SLOT_W+3:0] v;
        v = {{SLOT_W{1'b0}}, x};
        for (int i = 0; i < 8; i++) begin
            if (v >= (SLOT_W+4)'(TASK_SLOTS)) begin
                v = v - (SLOT_W+4)'(TASK_SLOTS);
            end
        end
        return v[SLOT_W-1:0];
    endfunction

    // Slot index to the 4-bit result field
    function automatic logic [3:0] slot_field(input logic [SLOT_W-1:0] s);
        logic [SLOT_W+3:0] v;
        v = {4'b0000, s};
        return v[3:0];
    endfunction

    // Fill count to the 5-bit result field
    function automatic logic [4:0] count_field(input logic [FILL_W-1:0] f);
        logic [FILL_W+4:0] v;
        v = {5'b00000, f};
        return v[4:0];
    endfunction

endpackage

// ===== hdl/rrts_queue.sv =====
// ----------------------------------------------------------------------------
// rrts_queue: ring deque of task slot numbers
// Push at tail or head, pop at head, one operation per cycle. A push to a
// full ring is dropped; the caller reads o_full to flag it.
// ----------------------------------------------------------------------------
module rrts_queue
    import rrts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_q_ctrl           i_ctrl,
    input  logic [SLOT_W-1:0] i_data,
    output logic [SLOT_W-1:0] o_head_data,
    output logic [FILL_W-1:0] o_fill,
    output logic              o_full
);

    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TASK_SLOTS - 1);

    logic [SLOT_W-1:0] r_ring [TASK_SLOTS];
    logic [SLOT_W-1:0] r_head, n_head;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [SLOT_W-1:0] head_dec, head_inc, tail_idx, wr_idx;
    logic [SLOT_W:0]   tail_sum;
    logic              wr_en;

    assign o_full      = (r_fill == FILL_W'(TASK_SLOTS));
    assign o_head_data = r_ring[r_head];
    assign o_fill      = r_fill;

    // Ring index arithmetic, wrapping at the slot count
    always_comb begin
        head_dec = (r_head == '0) ? LAST_IDX : r_head - 1'b1;
        head_inc = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
        tail_sum = {1'b0, r_head} + (SLOT_W+1)'(r_fill);
        if (tail_sum >= (SLOT_W+1)'(TASK_SLOTS)) begin
            tail_sum = tail_sum - (SLOT_W+1)'(TASK_SLOTS);
        end
        tail_idx = tail_sum[SLOT_W-1:0];
    end

    // Next pointer and fill
    always_comb begin
        n_head = r_head;
        n_fill = r_fill;
        wr_en  = 1'b0;
        wr_idx = tail_idx;
        if (i_ctrl.push && !o_full) begin
            wr_en  = 1'b1;
            n_fill = r_fill + 1'b1;
            if (i_ctrl.front) begin
                n_head = head_dec;
                wr_idx = head_dec;
            end
        end else if (i_ctrl.pop && (r_fill != '0)) begin
            n_head = head_inc;
            n_fill = r_fill - 1'b1;
        end
    end

    // Pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
        end
    end

    // Ring storage, no reset: entries are read only after being written
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ring[wr_idx] <= i_data;
        end
    end

endmodule

// ===== hdl/round_robin_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// round_robin_task_scheduler: round-robin scheduler over task slots
// Pipeline: the item is held in the input register, then the step result is
//   held in the result register until it transfers.
// Throughput: one item per cycle, set by the single-pass update of slot state
//   and queues between the two registers; a stalled result holds the input.
// Reset: synchronous, active low; clears queues, counters and slot states,
//   quantum to 10, running slot to 1. No clearing pass is needed.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler
    import rrts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input items
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_item                 i_in_item,
    // results
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_result               o_out_item,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers
    logic [15:0] r_qlen;
    logic [3:0]  r_idle;

    // Pipeline registers
    t_item   r_in;
    logic    r_in_vld;
    t_result r_out, n_out;
    logic    r_out_vld;
    logic    advance;

    // Scheduler state
    logic [15:0]       r_quantum, n_quantum;
    logic [SLOT_W-1:0] r_cur, n_cur;
    logic [1:0]        r_status [TASK_SLOTS];
    logic [1:0]        n_status [TASK_SLOTS];
    logic [31:0]       r_ticks    [TASK_SLOTS];
    logic [31:0]       r_switches [TASK_SLOTS];

    // Queue interface
    t_q_ctrl           rq_ctrl, wq_ctrl;
    logic [SLOT_W-1:0] rq_head, wq_head, q_data;
    logic [FILL_W-1:0] rq_fill, wq_fill;
    logic              rq_full, wq_full;

    // Step working values
    logic [SLOT_W-1:0] slot, idle, pick, shown;
    logic              do_tick, switched, full;
    logic [31:0]       tick_sum, sw_sum;

    // Handshakes
    assign advance     = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || advance;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen <= QUANTUM_RESET;
            r_idle <= 4'd0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_QUANTUM_LENGTH) begin
                r_qlen <= i_cfg_data[15:0];
            end else if (i_cfg_index == CFG_IDLE_SLOT) begin
                r_idle <= i_cfg_data[3:0];
            end
        end
    end

    rrts_queue u_ready_q (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (rq_ctrl),
        .i_data      (q_data),
        .o_head_data (rq_head),
        .o_fill      (rq_fill),
        .o_full      (rq_full)
    );

    rrts_queue u_wait_q (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (wq_ctrl),
        .i_data      (q_data),
        .o_head_data (wq_head),
        .o_fill      (wq_fill),
        .o_full      (wq_full)
    );

    // One step of the scheduler on the registered item
    always_comb begin
        slot      = slot_mod(r_in.task_slot);
        idle      = slot_mod(r_idle);
        q_data    = slot;
        rq_ctrl   = '0;
        wq_ctrl   = '0;
        n_quantum = r_quantum;
        n_cur     = r_cur;
        n_status  = r_status;
        pick      = idle;
        shown     = r_cur;
        do_tick   = 1'b0;
        switched  = 1'b0;
        full      = 1'b0;

        unique case (r_in.action)
            ACT_TICK: begin
                do_tick   = 1'b1;
                n_quantum = r_quantum - 16'd1;
            end
            ACT_ENQUEUE: begin
                unique case (r_in.target_list)
                    TGT_FREE:  n_status[slot] = TS_ZOMBIE;
                    TGT_READY: n_status[slot] = TS_READY;
                    default:   n_status[slot] = TS_BLOCKED;
                endcase
                if (slot != idle) begin
                    if (r_in.target_list == TGT_READY) begin
                        rq_ctrl.push = advance;
                        full         = rq_full;
                    end else if (r_in.target_list == TGT_KEYBOARD) begin
                        wq_ctrl.push  = advance;
                        wq_ctrl.front = r_in.keys_pending;
                        full          = wq_full;
                    end
                end
                shown = slot;
            end
            ACT_SCHEDULE: begin
                // keyboard waiter first when the receive buffer has data
                if (r_in.uart_has_data && (wq_fill != '0)) begin
                    pick        = wq_head;
                    wq_ctrl.pop = advance;
                end else if (rq_fill != '0) begin
                    pick        = rq_head;
                    rq_ctrl.pop = advance;
                end
                n_quantum = r_qlen;
                if (pick != r_cur) begin
                    n_status[r_cur] = TS_READY;
                    n_status[pick]  = TS_RUN;
                    n_cur           = pick;
                    switched        = 1'b1;
                end
                shown = pick;
            end
            ACT_NOP: begin
            end
        endcase

        // Counters of the slot running after the step, one read each
        tick_sum = r_ticks[n_cur] + 32'(do_tick);
        sw_sum   = r_switches[n_cur] + 32'(switched);

        n_out.running_slot    = slot_field(n_cur);
        n_out.switched        = switched;
        n_out.quantum_expired = (n_quantum == 16'd0);
        n_out.slot_state      = n_status[shown];
        n_out.switch_total    = sw_sum;
        n_out.tick_total      = tick_sum;
        n_out.queue_full      = full;
        n_out.ready_count     = count_field(rq_fill
                                    + FILL_W'(rq_ctrl.push && !rq_full)
                                    - FILL_W'(rq_ctrl.pop));
        n_out.waiting_count   = count_field(wq_fill
                                    + FILL_W'(wq_ctrl.push && !wq_full)
                                    - FILL_W'(wq_ctrl.pop));
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    // Scheduler state update on each completed step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= QUANTUM_RESET;
            r_cur     <= SLOT_W'(1);
            for (int i = 0; i < TASK_SLOTS; i++) begin
                r_status[i]   <= TS_READY;
                r_ticks[i]    <= '0;
                r_switches[i] <= '0;
            end
        end else if (advance) begin
            r_quantum <= n_quantum;
            r_cur     <= n_cur;
            r_status  <= n_status;
            if (do_tick) begin
                r_ticks[n_cur] <= tick_sum;
            end
            if (switched) begin
                r_switches[n_cur] <= sw_sum;
            end
        end
    end

    // Checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rq_fill <= FILL_W'(TASK_SLOTS)) && (wq_fill <= FILL_W'(TASK_SLOTS)))
        else $error("queue fill beyond slot count");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.queue_full) |->
            ((rq_fill == FILL_W'(TASK_SLOTS)) || (wq_fill == FILL_W'(TASK_SLOTS))))
        else $error("dropped push reported while no queue is full");

    a_switch_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && switched) |=> (r_out.slot_state == TS_RUN) && r_out.switched)
        else $error("switched-to slot not marked running");

    a_tick_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_in.action == ACT_TICK)) |=>
            (r_quantum == 16'($past(r_quantum) - 16'd1)))
        else $error("tick did not decrement the quantum");

endmodule
